// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros shared by the solver RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define NQBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, written as antecedent and consequent in the same cycle.
`define NQBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/nqbs_pkg.sv -----
// Shared types for the N-queens backtracking solver.
// No dependencies; imported by all solver modules.
package nqbs_pkg;

  // Field widths fixed by the stream payload
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned OUT_IDX_W = 4;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_POP,
    S_EMIT_RD,
    S_EMIT_LD,
    S_NONE
  } nqbs_state_t;

  // Command to the occupancy/conflict unit
  typedef struct packed {
    logic clear;
    logic place;
    logic remove;
  } board_cmd_t;

endpackage

// ----- rtl/core/nqbs_board.sv -----
// Occupancy masks (column, both diagonals) with the shared conflict check.
// Depends on nqbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nqbs_board import nqbs_pkg::*; #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  board_cmd_t                  cmd_i,
  input  logic [$clog2(MAX_SIZE)-1:0] row_i,
  input  logic [$clog2(MAX_SIZE)-1:0] col_i,
  output logic                        free_o
);

  localparam int unsigned DIAG_N = 2 * MAX_SIZE - 1;
  localparam int unsigned DW = $clog2(DIAG_N);

  logic [MAX_SIZE-1:0] col_mask_r, col_mask_nxt;
  logic [DIAG_N-1:0]   dn_mask_r, dn_mask_nxt;
  logic [DIAG_N-1:0]   up_mask_r, up_mask_nxt;
  logic [DW-1:0]       dn_idx;
  logic [DW-1:0]       up_idx;
  logic                occupied;

  assign dn_idx = DW'(row_i) + DW'(MAX_SIZE - 1) - DW'(col_i);
  assign up_idx = DW'(row_i) + DW'(col_i);

  assign free_o   = !col_mask_r[col_i] && !dn_mask_r[dn_idx] && !up_mask_r[up_idx];
  assign occupied = col_mask_r[col_i] && dn_mask_r[dn_idx] && up_mask_r[up_idx];

  always_comb begin
    col_mask_nxt = col_mask_r;
    dn_mask_nxt  = dn_mask_r;
    up_mask_nxt  = up_mask_r;
    if (cmd_i.clear) begin
      col_mask_nxt = '0;
      dn_mask_nxt  = '0;
      up_mask_nxt  = '0;
    end else if (cmd_i.place || cmd_i.remove) begin
      col_mask_nxt[col_i] = ~col_mask_r[col_i];
      dn_mask_nxt[dn_idx] = ~dn_mask_r[dn_idx];
      up_mask_nxt[up_idx] = ~up_mask_r[up_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_mask_r <= '0;
      dn_mask_r  <= '0;
      up_mask_r  <= '0;
    end else begin
      col_mask_r <= col_mask_nxt;
      dn_mask_r  <= dn_mask_nxt;
      up_mask_r  <= up_mask_nxt;
    end
  end

  `NQBS_ASSERT_IMPL(a_place_free, clk, rst_n, cmd_i.place, free_o, "queen placed on attacked cell")
  `NQBS_ASSERT_IMPL(a_remove_held, clk, rst_n, cmd_i.remove, occupied, "removed queen not present")
  `NQBS_ASSERT(a_mask_counts, clk, rst_n, ($countones(col_mask_r) == $countones(dn_mask_r)) && ($countones(col_mask_r) == $countones(up_mask_r)), "mask populations diverged")

endmodule

// ----- rtl/core/nqbs_store.sv -----
// Per-row queen column stack: one write port, one registered read port.
// Depends on nqbs_pkg.
module nqbs_store import nqbs_pkg::*; #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                        clk,
  input  logic                        we_i,
  input  logic [$clog2(MAX_SIZE)-1:0] waddr_i,
  input  logic [$clog2(MAX_SIZE)-1:0] wdata_i,
  input  logic [$clog2(MAX_SIZE)-1:0] raddr_i,
  output logic [$clog2(MAX_SIZE)-1:0] rdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SIZE);

  logic [IDX_W-1:0] mem [MAX_SIZE];
  logic [IDX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ----- rtl/core/n_queens_backtrack_solver_unit.sv -----
// N-queens first-solution search: sequencer, column stack and output register.
// Depends on nqbs_pkg, nqbs_board, nqbs_store and assert_macros.svh.
//
// Each input transaction carries a board size; the unit searches depth-first for
// the first placement and returns one transaction per row (found=1, row, column,
// tlast on the final row) or a single found=0 transaction with tlast set. Sizes
// of zero or above MAX_SIZE give the not-found answer. in_tready is high only
// while no search runs. The shared conflict check tests one candidate column
// per cycle, each backtrack is a stack read and then the queen removal, and
// each reported row is a stack read and then an output load, which waits while
// the output register still holds an untaken result. At size 16 about ten
// thousand queens are placed and removed before the first placement turns up.
// The previous result may still be waiting in the output register when the
// next board size is taken.
`include "assert_macros.svh"

module n_queens_backtrack_solver_unit import nqbs_pkg::*; #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] board_size, [7:5] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] found, [4:1] row_index,
                                             // [8:5] queen_column, [15:9] zero
  output logic                   out_tlast
);

  localparam int unsigned IDX_W = $clog2(MAX_SIZE);
  localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1);
  localparam logic [SIZE_W:0] MAX_SIZE_V = (SIZE_W + 1)'(MAX_SIZE);

  nqbs_state_t state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic [CNT_W-1:0] row_dec;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [OUT_IDX_W-1:0] out_row_r, out_row_nxt;
  logic [OUT_IDX_W-1:0] out_col_r, out_col_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_free;

  logic [SIZE_W-1:0] in_size;
  logic              size_ok;

  board_cmd_t       bcmd;
  logic [IDX_W-1:0] b_row, b_col;
  logic             b_free;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr, st_wdata, st_raddr, st_rdata;

  nqbs_board #(.MAX_SIZE(MAX_SIZE)) u_board (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (bcmd),
    .row_i  (b_row),
    .col_i  (b_col),
    .free_o (b_free)
  );

  nqbs_store #(.MAX_SIZE(MAX_SIZE)) u_store (
    .clk     (clk),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign in_size  = in_tdata[SIZE_W-1:0];
  assign size_ok  = (in_size != '0) && ({1'b0, in_size} <= MAX_SIZE_V);
  assign out_free = !out_valid_r || out_tready;
  assign row_dec  = row_r - CNT_W'(1);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    bcmd          = '0;
    b_row         = row_r[IDX_W-1:0];
    b_col         = col_r[IDX_W-1:0];
    st_we         = 1'b0;
    st_waddr      = row_r[IDX_W-1:0];
    st_wdata      = col_r[IDX_W-1:0];
    st_raddr      = emit_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (size_ok) begin
            n_nxt      = CNT_W'(in_size);
            row_nxt    = '0;
            col_nxt    = '0;
            bcmd.clear = 1'b1;
            state_nxt  = S_SEARCH;
          end else begin
            state_nxt = S_NONE;
          end
        end
      end
      S_SEARCH: begin
        if (row_r == n_r) begin
          emit_nxt  = '0;
          state_nxt = S_EMIT_RD;
        end else if (col_r == n_r) begin
          if (row_r == '0) begin
            state_nxt = S_NONE;
          end else begin
            // step back one row; its column comes out of the stack next cycle
            row_nxt   = row_dec;
            st_raddr  = row_dec[IDX_W-1:0];
            state_nxt = S_POP;
          end
        end else if (b_free) begin
          bcmd.place = 1'b1;
          st_we      = 1'b1;
          row_nxt    = row_r + CNT_W'(1);
          col_nxt    = '0;
        end else begin
          col_nxt = col_r + CNT_W'(1);
        end
      end
      S_POP: begin
        b_col       = st_rdata;
        bcmd.remove = 1'b1;
        col_nxt     = CNT_W'(st_rdata) + CNT_W'(1);
        state_nxt   = S_SEARCH;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_row_nxt   = OUT_IDX_W'(emit_r);
          out_col_nxt   = OUT_IDX_W'(st_rdata);
          out_last_nxt  = (emit_r + CNT_W'(1) == n_r);
          emit_nxt      = emit_r + CNT_W'(1);
          state_nxt     = (emit_r + CNT_W'(1) == n_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - 2 * OUT_IDX_W - 1)'(0), out_col_r, out_row_r,
                       out_found_r};

  `NQBS_ASSERT_IMPL(a_search_row_bound, clk, rst_n, state_r == S_SEARCH, row_r <= n_r, "row ran past board size")
  `NQBS_ASSERT_IMPL(a_pop_row_bound, clk, rst_n, state_r == S_POP, row_r < n_r, "backtrack row out of range")

endmodule

// ----- tb/tb_n_queens_backtrack_solver_unit.sv -----
// Self-checking testbench for n_queens_backtrack_solver_unit: streams board sizes in,
// predicts each search's first placement row by row, and checks the result stream.
// Depends on nqbs_pkg and the solver RTL only.
module tb_n_queens_backtrack_solver_unit import nqbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BOARD = 16;
  localparam int TAIL_CALM = 15;

  typedef struct packed {
    logic       found;
    logic [3:0] row;
    logic [3:0] col;
    logic       last;
  } queen_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  n_queens_backtrack_solver_unit #(.MAX_SIZE(MAX_BOARD)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: column stack and occupancy masks
  logic [SIZE_W-1:0]      stack_col [MAX_BOARD];
  logic [SIZE_W-1:0]      cur_row;
  logic [SIZE_W-1:0]      cand_col;
  logic [MAX_BOARD-1:0]   col_occ;
  logic [2*MAX_BOARD-2:0] dn_occ;
  logic [2*MAX_BOARD-2:0] up_occ;

  logic [SIZE_W-1:0] board_q [$];
  queen_row_t        placement_q [$];

  int     n_total = 0;
  int     in_cnt = 0;
  int     err_cnt = 0;
  int     rows_checked = 0;
  int     n_solved = 0;
  int     n_unsolvable = 0;
  logic [31:0] sizes_seen = '0;
  logic   in_fire = 1'b0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  logic   calm;

  assign calm = (in_cnt >= n_total - TAIL_CALM);

  function automatic bit cell_clear(int r, int c);
    return !col_occ[c] && !dn_occ[r + MAX_BOARD - 1 - c] && !up_occ[r + c];
  endfunction

  function automatic void flip_queen(int r, int c);
    col_occ[c] = ~col_occ[c];
    dn_occ[r + MAX_BOARD - 1 - c] = ~dn_occ[r + MAX_BOARD - 1 - c];
    up_occ[r + c] = ~up_occ[r + c];
  endfunction

  // Depth-first search for the first placement; queues the rows it yields, or one not-found entry
  function automatic void predict_placement(logic [SIZE_W-1:0] n);
    bit         solved;
    bit         searching;
    queen_row_t r;
    solved = 1'b0;
    cur_row = '0;
    cand_col = '0;
    col_occ = '0;
    dn_occ = '0;
    up_occ = '0;
    searching = (n >= 1 && n <= MAX_BOARD);
    while (searching) begin
      if (cur_row >= n) begin
        solved = 1'b1;
        searching = 1'b0;
      end else if (cand_col >= n) begin
        if (cur_row == 0) begin
          searching = 1'b0;
        end else begin
          cur_row = cur_row - 1'b1;
          cand_col = stack_col[cur_row];
          flip_queen(cur_row, cand_col);
          cand_col = cand_col + 1'b1;
        end
      end else if (cell_clear(cur_row, cand_col)) begin
        flip_queen(cur_row, cand_col);
        stack_col[cur_row] = cand_col;
        cur_row = cur_row + 1'b1;
        cand_col = '0;
      end else begin
        cand_col = cand_col + 1'b1;
      end
    end
    if (!solved) begin
      r = '{found: 1'b0, row: 4'd0, col: 4'd0, last: 1'b1};
      placement_q.push_back(r);
      n_unsolvable++;
    end else begin
      for (int i = 0; i < n; i++) begin
        r.found = 1'b1;
        r.row = i[3:0];
        r.col = stack_col[i][3:0];
        r.last = (i == n - 1);
        placement_q.push_back(r);
      end
      n_solved++;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Sender: one board size per transaction, random idle bursts until the tail
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (board_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        gap_left <= $urandom_range(0, 4);
      end else begin
        in_tdata <= {3'b000, board_q.pop_front()};
        in_tvalid <= 1'b1;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_cnt >= 30) begin
      out_tready <= 1'b0;
      hold_left <= 399;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: results are checked before the new size is predicted
  always @(posedge clk) begin
    queen_row_t got;
    queen_row_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got = '{found: out_tdata[0], row: out_tdata[4:1], col: out_tdata[8:5],
                last: out_tlast};
        if (placement_q.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", out_tdata, 0);
        end else begin
          want = placement_q.pop_front();
          rows_checked++;
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.row !== want.row) report_mismatch("row_index", got.row, want.row);
          if (got.col !== want.col) report_mismatch("queen_column", got.col, want.col);
          if (got.last !== want.last) report_mismatch("tlast", got.last, want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_placement(in_tdata[SIZE_W-1:0]);
        sizes_seen[in_tdata[SIZE_W-1:0]] = 1'b1;
        in_cnt <= in_cnt + 1;
      end
    end
  end

  initial begin
    int pick;
    // directed: empty, trivial, unsolvable, legal max, oversize, all-ones
    board_q = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
                5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd31,
                5'd1, 5'd16, 5'd20};
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) board_q.push_back(SIZE_W'($urandom_range(0, 12)));
      else if (pick < 19) board_q.push_back(SIZE_W'($urandom_range(17, 31)));
      else board_q.push_back($urandom_range(0, 1) ? 5'd13 : 5'd16);
    end
    n_total = board_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_cnt < n_total || placement_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("%0d board sizes searched (%0d solved, %0d with no placement), %0d rows checked",
             in_cnt, n_solved, n_unsolvable, rows_checked);
    $display("distinct sizes covered: %0d of 32", $countones(sizes_seen));
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout: %0d of %0d sizes taken, %0d rows pending",
             in_cnt, n_total, placement_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/nqbs_pkg.sv
rtl/core/nqbs_board.sv
rtl/core/nqbs_store.sv
rtl/core/n_queens_backtrack_solver_unit.sv
tb/tb_n_queens_backtrack_solver_unit.sv
